### sv/cbpg_pkg.sv
package cbpg_pkg;

  // Number of curve steps is 2**STEPS_LOG2; the supported range is 1 to 12.
  localparam int STEPS_LOG2 = 10;
  localparam int STEP_W     = STEPS_LOG2 + 1;
  localparam int SQ_W       = 2 * STEPS_LOG2 + 1;
  localparam int W_W        = 3 * STEPS_LOG2 + 1;
  localparam int CW         = 10;
  localparam int PT_W       = 14;
  localparam int MA_W       = W_W;
  localparam int MB_W       = (STEP_W + 1 > CW) ? STEP_W + 1 : CW;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int NUM_W      = 3 * STEPS_LOG2 + CW;
  localparam int RND_W      = NUM_W + 4;

  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [STEP_W-1:0] STEPS_V  = STEP_W'(1) << STEPS_LOG2;
  localparam logic [RND_W-1:0]  RND_HALF = RND_W'(1) << (3 * STEPS_LOG2 - 1);

  localparam logic [2:0] REG_CTRL_X0 = 3'd0;
  localparam logic [2:0] REG_CTRL_X1 = 3'd1;
  localparam logic [2:0] REG_CTRL_X2 = 3'd2;
  localparam logic [2:0] REG_CTRL_X3 = 3'd3;
  localparam logic [2:0] REG_CTRL_Y0 = 3'd4;
  localparam logic [2:0] REG_CTRL_Y1 = 3'd5;
  localparam logic [2:0] REG_CTRL_Y2 = 3'd6;
  localparam logic [2:0] REG_CTRL_Y3 = 3'd7;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    logic [3:0][CW-1:0] x;
    logic [3:0][CW-1:0] y;
  } ctrl_pts_t;

  typedef struct packed {
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
    logic            last;
  } point_t;

  // Scales the exact numerator to 1/16 pixel, rounding half up.
  function automatic logic [PT_W-1:0] round_point(input logic [NUM_W-1:0] num);
    logic [RND_W-1:0] t;
    t = {num, 4'b0000} + RND_HALF;
    return t[RND_W-1 -: PT_W];
  endfunction

endpackage

### sv/cbpg_cfg.sv
module cbpg_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [cbpg_pkg::DATA_W-1:0]   pwdata,
  output logic [cbpg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output cbpg_pkg::ctrl_pts_t           pts
);
  import cbpg_pkg::*;

  ctrl_pts_t  pts_r;
  ctrl_pts_t  pts_nxt;
  logic [2:0] idx;
  logic [CW-1:0] rd_val;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign pts    = pts_r;

  always_comb begin
    pts_nxt = pts_r;
    if (wr_en) begin
      case (idx)
        REG_CTRL_X0: pts_nxt.x[0] = pwdata[CW-1:0];
        REG_CTRL_X1: pts_nxt.x[1] = pwdata[CW-1:0];
        REG_CTRL_X2: pts_nxt.x[2] = pwdata[CW-1:0];
        REG_CTRL_X3: pts_nxt.x[3] = pwdata[CW-1:0];
        REG_CTRL_Y0: pts_nxt.y[0] = pwdata[CW-1:0];
        REG_CTRL_Y1: pts_nxt.y[1] = pwdata[CW-1:0];
        REG_CTRL_Y2: pts_nxt.y[2] = pwdata[CW-1:0];
        REG_CTRL_Y3: pts_nxt.y[3] = pwdata[CW-1:0];
        default: pts_nxt = pts_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CTRL_X0: rd_val = pts_r.x[0];
      REG_CTRL_X1: rd_val = pts_r.x[1];
      REG_CTRL_X2: rd_val = pts_r.x[2];
      REG_CTRL_X3: rd_val = pts_r.x[3];
      REG_CTRL_Y0: rd_val = pts_r.y[0];
      REG_CTRL_Y1: rd_val = pts_r.y[1];
      REG_CTRL_Y2: rd_val = pts_r.y[2];
      REG_CTRL_Y3: rd_val = pts_r.y[3];
      default:     rd_val = '0;
    endcase
  end

  assign prdata = DATA_W'(rd_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= '0;
    end else begin
      pts_r <= pts_nxt;
    end
  end

endmodule

### sv/cbpg_mul.sv
module cbpg_mul (
  input  logic                          clk,
  input  logic [cbpg_pkg::MA_W-1:0]     a,
  input  logic [cbpg_pkg::MB_W-1:0]     b,
  output logic [cbpg_pkg::PROD_W-1:0]   prod
);
  import cbpg_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(a) * PROD_W'(b);
  assign prod     = prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

### sv/cbpg_core.sv
module cbpg_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_restart,
  output logic                   in_ready,
  input  cbpg_pkg::ctrl_pts_t    pts,
  input  logic                   slot_free,
  output logic                   fire,
  output cbpg_pkg::point_t       res
);
  import cbpg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // One multiplication per phase; its product is consumed in the next phase.
  localparam logic [3:0] PH_UU  = 4'd0;
  localparam logic [3:0] PH_KK  = 4'd1;
  localparam logic [3:0] PH_W0  = 4'd2;
  localparam logic [3:0] PH_W1  = 4'd3;
  localparam logic [3:0] PH_W2  = 4'd4;
  localparam logic [3:0] PH_W3  = 4'd5;
  localparam logic [3:0] PH_X0  = 4'd6;
  localparam logic [3:0] PH_X3  = 4'd9;
  localparam logic [3:0] PH_Y0  = 4'd10;
  localparam logic [3:0] PH_Y3  = 4'd13;
  localparam logic [3:0] PH_END = 4'd14;

  logic [1:0]             state_r, state_nxt;
  logic [3:0]             ph_r, ph_nxt;
  step_t                  k_r, k_nxt;
  logic [SQ_W-1:0]        uu_r, uu_nxt;
  logic [SQ_W-1:0]        kk_r, kk_nxt;
  logic [3:0][W_W-1:0]    w_r, w_nxt;
  logic [NUM_W-1:0]       acc_x_r, acc_x_nxt;
  logic [NUM_W-1:0]       acc_y_r, acc_y_nxt;

  step_t                  u;
  logic [STEP_W:0]        k3;
  logic [STEP_W:0]        u3;
  logic [3:0]             pw;
  logic [3:0]             xi;
  logic [3:0]             yi;
  logic [3:0]             wi;
  logic [MA_W-1:0]        mul_a;
  logic [MB_W-1:0]        mul_b;
  logic [PROD_W-1:0]      prod;
  logic                   last;

  assign u    = STEPS_V - k_r;
  assign k3   = {k_r, 1'b0} + (STEP_W+1)'(k_r);
  assign u3   = {u, 1'b0} + (STEP_W+1)'(u);
  assign pw   = ph_r - 4'd1;
  assign xi   = ph_r - PH_X0;
  assign yi   = ph_r - PH_Y0;
  assign wi   = pw - PH_W0;
  assign last = (k_r == STEPS_V);

  assign in_ready = (state_r == ST_IDLE);
  assign fire     = (state_r == ST_DONE) && slot_free;
  assign res.x    = round_point(acc_x_r);
  assign res.y    = round_point(acc_y_r);
  assign res.last = last;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ph_r) inside
      PH_UU: begin
        mul_a = MA_W'(u);
        mul_b = MB_W'(u);
      end
      PH_KK: begin
        mul_a = MA_W'(k_r);
        mul_b = MB_W'(k_r);
      end
      PH_W0: begin
        mul_a = MA_W'(uu_r);
        mul_b = MB_W'(u);
      end
      PH_W1: begin
        mul_a = MA_W'(uu_r);
        mul_b = MB_W'(k3);
      end
      PH_W2: begin
        mul_a = MA_W'(kk_r);
        mul_b = MB_W'(u3);
      end
      PH_W3: begin
        mul_a = MA_W'(kk_r);
        mul_b = MB_W'(k_r);
      end
      [PH_X0:PH_X3]: begin
        mul_a = MA_W'(w_r[xi[1:0]]);
        mul_b = MB_W'(pts.x[xi[1:0]]);
      end
      [PH_Y0:PH_Y3]: begin
        mul_a = MA_W'(w_r[yi[1:0]]);
        mul_b = MB_W'(pts.y[yi[1:0]]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cbpg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    k_nxt     = k_r;
    uu_nxt    = uu_r;
    kk_nxt    = kk_r;
    w_nxt     = w_r;
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          ph_nxt    = PH_UU;
          acc_x_nxt = '0;
          acc_y_nxt = '0;
          if (in_restart) begin
            k_nxt = '0;
          end
        end
      end
      ST_RUN: begin
        ph_nxt = ph_r + 4'd1;
        if (ph_r == PH_END) begin
          state_nxt = ST_DONE;
        end
        case (pw) inside
          PH_UU:         uu_nxt = prod[SQ_W-1:0];
          PH_KK:         kk_nxt = prod[SQ_W-1:0];
          [PH_W0:PH_W3]: w_nxt[wi[1:0]] = prod[W_W-1:0];
          [PH_X0:PH_X3]: acc_x_nxt = acc_x_r + prod[NUM_W-1:0];
          [PH_Y0:PH_Y3]: acc_y_nxt = acc_y_r + prod[NUM_W-1:0];
          default:       uu_nxt = uu_r;
        endcase
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
          k_nxt     = last ? '0 : k_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= PH_UU;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    uu_r    <= uu_nxt;
    kk_r    <= kk_nxt;
    w_r     <= w_nxt;
    acc_x_r <= acc_x_nxt;
    acc_y_r <= acc_y_nxt;
  end

endmodule

### sv/cubic_bezier_point_generator.sv
// One request is worked on at a time: the sequencer takes no new request until
// its point has passed to the result register. The single shared multiplier forms
// u*u, k*k, the four Bernstein weights and eight weight-by-coordinate products.
// The result register lets the next request start while a point waits.
// Reset (rst_n low, synchronous) clears all control points, the step index
// and the output valid flag.
module cubic_bezier_point_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cbpg_pkg::PT_W-1:0]     out_point_x,
  output logic [cbpg_pkg::PT_W-1:0]     out_point_y,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [cbpg_pkg::DATA_W-1:0]   pwdata,
  output logic [cbpg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import cbpg_pkg::*;

  ctrl_pts_t pts;
  point_t    res;
  logic      fire;
  logic      slot_free;
  logic      out_valid_r, out_valid_nxt;
  point_t    out_pt_r, out_pt_nxt;

  cbpg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pts     (pts)
  );

  cbpg_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_ready   (in_ready),
    .pts        (pts),
    .slot_free  (slot_free),
    .fire       (fire),
    .res        (res)
  );

  // The output slot frees up in the same cycle as its transfer.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pt_nxt    = out_pt_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_pt_nxt    = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pt_r <= out_pt_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = out_pt_r.x;
  assign out_point_y = out_pt_r.y;
  assign out_last    = out_pt_r.last;

endmodule

### sv/cbpg_chk.sv
module cbpg_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [cbpg_pkg::PT_W-1:0]     out_point_x,
  input  logic [cbpg_pkg::PT_W-1:0]     out_point_y,
  input  logic                          out_last
);

  // Once a request is taken the block stays busy and takes no new request straight after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("request taken again too soon after a transfer");

  // A new point is only ever presented as the sequencer returns to idle.
  a_ready_with_point: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("point presented while the sequencer is still busy");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped before transfer");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(out_point_x) && $stable(out_point_y) && $stable(out_last)))
    else $error("output payload changed while stalled");

endmodule

bind cubic_bezier_point_generator cbpg_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_point_x (out_point_x),
  .out_point_y (out_point_y),
  .out_last    (out_last)
);

### tb/sv/tb_cubic_bezier_point_generator.sv
module tb_cubic_bezier_point_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import cbpg_pkg::*;

  localparam longint unsigned CURVE_STEPS = 64'd1 << STEPS_LOG2;
  localparam int SWEEP_LEN = int'(CURVE_STEPS) + 6;
  localparam logic [7:0][2:0] CTRL_REG_ORDER = {REG_CTRL_Y3, REG_CTRL_Y2, REG_CTRL_Y1,
                                                REG_CTRL_Y0, REG_CTRL_X3, REG_CTRL_X2,
                                                REG_CTRL_X1, REG_CTRL_X0};

  typedef struct {
    logic restart;
    bit   drain_first;
  } point_req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_restart = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PT_W-1:0]     out_point_x;
  logic [PT_W-1:0]     out_point_y;
  logic                out_last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  cubic_bezier_point_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_restart  (in_restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y),
    .out_last    (out_last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Curve state mirrored by the testbench.
  logic [3:0][CW-1:0] ctrl_x_m = '0;
  logic [3:0][CW-1:0] ctrl_y_m = '0;
  longint unsigned    step_k = 0;

  point_req_t         req_q[$];
  point_t             point_q[$];
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  bit                 in_taken = 1'b0;
  int                 errors = 0;
  int                 points_seen = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < 30) begin
      $display("mismatch on %s at point %0d: got %0d, expected %0d",
               what, points_seen, got, want);
    end
    errors++;
  endtask

  function automatic logic [PT_W-1:0] bezier_coord(input logic [3:0][CW-1:0] p,
                                                   input longint unsigned k);
    longint unsigned u;
    longint unsigned s3;
    longint unsigned num;
    u   = CURVE_STEPS - k;
    s3  = CURVE_STEPS * CURVE_STEPS * CURVE_STEPS;
    num = u * u * u * longint'(p[0])
        + 3 * u * u * k * longint'(p[1])
        + 3 * u * k * k * longint'(p[2])
        + k * k * k * longint'(p[3]);
    return PT_W'((16 * num + s3 / 2) / s3);
  endfunction

  task automatic advance_curve(input logic restart, output point_t pt);
    longint unsigned k;
    if (restart) step_k = 0;
    k = (step_k > CURVE_STEPS) ? CURVE_STEPS : step_k;
    pt.x    = bezier_coord(ctrl_x_m, k);
    pt.y    = bezier_coord(ctrl_y_m, k);
    pt.last = (k == CURVE_STEPS);
    step_k  = pt.last ? 0 : k + 1;
  endtask

  // Result checking and prediction share one block so that a point leaving
  // and a request arriving on the same edge are handled in a fixed order.
  always @(posedge clk) begin : point_monitor
    point_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (point_q.size() == 0) begin
          report_mismatch("unexpected point transfer", out_point_x, -1);
        end else begin
          want = point_q.pop_front();
          if (out_point_x !== want.x) report_mismatch("point_x", out_point_x, want.x);
          if (out_point_y !== want.y) report_mismatch("point_y", out_point_y, want.y);
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        end
        points_seen++;
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        advance_curve(in_restart, want);
        point_q.push_back(want);
      end
    end
  end

  always @(negedge clk) begin : request_driver
    point_req_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(req_q[0].drain_first && point_q.size() != 0)) begin
        cur = req_q.pop_front();
        in_valid   <= 1'b1;
        in_restart <= cur.restart;
      end else begin
        in_valid   <= 1'b0;
        in_restart <= 1'($urandom_range(1));
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_ctrl(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < REG_CTRL_Y0) ctrl_x_m[idx[1:0]] = value[CW-1:0];
    else ctrl_y_m[idx[1:0]] = value[CW-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_ctrl(input logic [2:0] idx);
    logic [DATA_W-1:0] want;
    want = (idx < REG_CTRL_Y0) ? DATA_W'(ctrl_x_m[idx[1:0]]) : DATA_W'(ctrl_y_m[idx[1:0]]);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= DATA_W'($urandom());
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_ctrl(input logic [7:0][DATA_W-1:0] vals);
    for (int i = 0; i < 8; i++) write_ctrl(CTRL_REG_ORDER[i], vals[i]);
    for (int i = 0; i < 8; i++) check_ctrl(CTRL_REG_ORDER[i]);
  endtask

  task automatic push_req(input logic restart, input bit drain_first = 1'b0);
    point_req_t r;
    r.restart     = restart;
    r.drain_first = drain_first;
    req_q.push_back(r);
  endtask

  // Mostly free-running points with an occasional restart.
  task automatic push_random_reqs(input int n);
    for (int i = 0; i < n; i++) push_req($urandom_range(19) == 0);
  endtask

  // A restart followed by an unbroken run past the curve end and round again.
  task automatic push_sweep();
    push_req(1'b1);
    for (int i = 0; i < SWEEP_LEN; i++) push_req(1'b0);
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || in_valid || point_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0][DATA_W-1:0] setting;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Points from the reset control points, then a curve from corner to corner.
    push_req(1'b0);
    push_req(1'b0);
    push_req(1'b1);
    wait_idle();
    setting = '0;
    setting[REG_CTRL_X2] = 32'd1023;
    setting[REG_CTRL_X3] = 32'd1023;
    setting[REG_CTRL_Y0] = 32'd1023;
    setting[REG_CTRL_Y1] = 32'd1023;
    load_ctrl(setting);
    push_req(1'b1);
    push_req(1'b0);
    push_req(1'b0);
    push_req(1'b1);
    push_req(1'b1);
    push_req(1'b0);
    push_req(1'b0, 1'b1);
    push_req(1'b0);
    push_req(1'b1);
    push_req(1'b0);
    push_sweep();
    wait_idle();

    // Every bit set, upper bits included, so only the low bits may be kept.
    send_idle_pct  = 58;
    recv_stall_pct = 0;
    for (int i = 0; i < 8; i++) setting[i] = 32'hFFFF_FFFF;
    load_ctrl(setting);
    push_random_reqs(30);
    push_req(1'b0, 1'b1);
    push_random_reqs(30);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 58;
    for (int i = 0; i < 8; i++) setting[i] = $urandom();
    load_ctrl(setting);
    push_random_reqs(30);
    push_req(1'b1, 1'b1);
    push_random_reqs(30);
    wait_idle();

    send_idle_pct  = 32;
    recv_stall_pct = 32;
    for (int i = 0; i < 8; i++) setting[i] = $urandom();
    load_ctrl(setting);
    push_random_reqs(60);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    setting = '0;
    load_ctrl(setting);
    push_random_reqs(10);
    wait_idle();
    for (int i = 0; i < 8; i++) setting[i] = $urandom();
    load_ctrl(setting);
    push_random_reqs(30);
    wait_idle();

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("** cubic_bezier_point_generator: PASSED **");
    end else begin
      $display("** cubic_bezier_point_generator: FAILED **");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("** cubic_bezier_point_generator: FAILED **");
    $finish;
  end

endmodule
